@@ src/bsim_pkg.sv @@
// Shared types, codes and constants of the bank switch IRQ mapper.
`default_nettype none
package bsim_pkg;

    typedef enum logic [2:0] {
        CMD_WRITE = 3'd0,
        CMD_CYCLE = 3'd1,
        CMD_LINE  = 3'd2,
        CMD_PRG   = 3'd3,
        CMD_PPU   = 3'd4
    } cmd_t;

    localparam logic [15:0] REG_MASK      = 16'hF001;
    localparam logic [15:0] REG_COMMAND   = 16'h8000;
    localparam logic [15:0] REG_BANK      = 16'h8001;
    localparam logic [15:0] REG_MIRROR    = 16'hA000;
    localparam logic [15:0] REG_LATCH     = 16'hC000;
    localparam logic [15:0] REG_MODE      = 16'hC001;
    localparam logic [15:0] REG_IRQ_ACK   = 16'hE000;
    localparam logic [15:0] REG_IRQ_EN    = 16'hE001;

    localparam logic [3:0]  BANK_PRG0       = 4'd6;
    localparam logic [3:0]  BANK_PRG1       = 4'd7;
    localparam logic [3:0]  BANK_PRG2       = 4'd15;
    localparam logic [3:0]  BANK_CHR_HIGH   = 4'd2;
    localparam logic [3:0]  BANK_CHR_ALT    = 4'd8;
    localparam logic [3:0]  BANK_RESET_LAST = 4'd10;
    localparam logic [7:0]  BANK_LAST       = 8'hFF;
    localparam int          CMD_ONE_K_BIT   = 5;
    localparam logic [8:0]  LINE_SKIP       = 9'd240;
    localparam int          PRESCALE_BITS   = 2;
    localparam int          CYCLE_BITS      = 4;
    localparam int          SUM_BITS        = CYCLE_BITS + 1;
    localparam int          TICK_BITS       = SUM_BITS - PRESCALE_BITS;

    typedef struct packed {
        logic                     latch_wr;
        logic                     mode_wr;
        logic                     ack;
        logic                     enable;
        logic                     line_clk;
        logic                     cyc_clk;
        logic                     pre_load;
        logic [PRESCALE_BITS-1:0] pre_value;
    } irq_ctrl_t;

    typedef struct packed {
        logic                     cycle_mode;
        logic                     pending;
        logic [PRESCALE_BITS-1:0] prescaler;
    } irq_status_t;

    function automatic logic [7:0] bank_reset_value(input logic [3:0] idx);
        return (idx <= BANK_RESET_LAST) ? 8'hFF : 8'h00;
    endfunction

endpackage
`default_nettype wire

@@ src/bsim_if.sv @@
// Handshake interfaces for request, response and configuration transactions.
`default_nettype none
interface bsim_req_if;
    logic       valid;
    logic       ready;
    logic [2:0] command;
    logic [15:0] address;
    logic [7:0] write_data;
    logic [3:0] cycle_count;
    logic [8:0] line_number;
    modport source (output valid, command, address, write_data, cycle_count, line_number,
                    input ready);
    modport sink (input valid, command, address, write_data, cycle_count, line_number,
                  output ready);
endinterface

interface bsim_rsp_if;
    logic       valid;
    logic       ready;
    logic       irq_line;
    logic [7:0] bank_number;
    logic       nametable_page;
    modport source (output valid, irq_line, bank_number, nametable_page, input ready);
    modport sink (input valid, irq_line, bank_number, nametable_page, output ready);
endinterface

interface bsim_cfg_if;
    logic valid;
    logic ready;
    logic variant_alt_nametable;
    modport source (output valid, variant_alt_nametable, input ready);
    modport sink (input valid, variant_alt_nametable, output ready);
endinterface
`default_nettype wire

@@ src/bsim_bank_store.sv @@
// Sixteen-entry bank register store with reset-value valid bits and a registered read.
`default_nettype none
module bsim_bank_store
    import bsim_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       wr_en,
    input  wire logic [3:0] wr_idx,
    input  wire logic [7:0] wr_data,
    input  wire logic [3:0] rd_idx,
    output logic      [7:0] rd_data
);

    logic [7:0]  mem [16];
    logic [15:0] valid_reg;
    logic [7:0]  rd_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (wr_en)
        begin
            valid_reg[wr_idx] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_idx] <= wr_data;
        end
        rd_data_reg <= valid_reg[rd_idx] ? mem[rd_idx] : bank_reset_value(rd_idx);
    end

    assign rd_data = rd_data_reg;

endmodule
`default_nettype wire

@@ src/bsim_irq_unit.sv @@
// IRQ latch, counter with shared decrementer, prescaler and pending flag.
`default_nettype none
module bsim_irq_unit
    import bsim_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire irq_ctrl_t   ctrl,
    input  wire logic [7:0]  data,
    output irq_status_t      status
);

    logic [7:0]               latch_reg, latch_next;
    logic [7:0]               counter_reg, counter_next;
    logic                     reload_reg, reload_next;
    logic                     mode_reg, mode_next;
    logic                     enable_reg, enable_next;
    logic                     pending_reg, pending_next;
    logic [PRESCALE_BITS-1:0] pre_reg, pre_next;
    logic [7:0]               cnt_dec;
    logic                     wrap;

    assign cnt_dec = counter_reg - 8'd1;
    assign wrap    = (counter_reg == 8'h00) && enable_reg;

    always_comb
    begin
        latch_next   = latch_reg;
        counter_next = counter_reg;
        reload_next  = reload_reg;
        mode_next    = mode_reg;
        enable_next  = enable_reg;
        pending_next = pending_reg;
        pre_next     = pre_reg;
        if (ctrl.latch_wr)
        begin
            latch_next = data;
            if (reload_reg)
            begin
                counter_next = data;
            end
        end
        if (ctrl.mode_wr)
        begin
            reload_next  = 1'b1;
            counter_next = latch_reg;
            mode_next    = data[0];
        end
        if (ctrl.ack)
        begin
            enable_next  = 1'b0;
            pending_next = 1'b0;
            if (reload_reg)
            begin
                counter_next = latch_reg;
            end
        end
        if (ctrl.enable)
        begin
            enable_next = 1'b1;
            if (reload_reg)
            begin
                counter_next = latch_reg;
            end
        end
        if (ctrl.line_clk)
        begin
            reload_next  = wrap;
            counter_next = cnt_dec;
            if (wrap)
            begin
                pending_next = 1'b1;
            end
        end
        if (ctrl.cyc_clk)
        begin
            counter_next = cnt_dec;
            if (wrap)
            begin
                pending_next = 1'b1;
            end
        end
        if (ctrl.pre_load)
        begin
            pre_next = ctrl.pre_value;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            latch_reg   <= '0;
            counter_reg <= '0;
            reload_reg  <= 1'b0;
            mode_reg    <= 1'b0;
            enable_reg  <= 1'b0;
            pending_reg <= 1'b0;
            pre_reg     <= '0;
        end
        else
        begin
            latch_reg   <= latch_next;
            counter_reg <= counter_next;
            reload_reg  <= reload_next;
            mode_reg    <= mode_next;
            enable_reg  <= enable_next;
            pending_reg <= pending_next;
            pre_reg     <= pre_next;
        end
    end

    assign status.cycle_mode = mode_reg;
    assign status.pending    = pending_reg;
    assign status.prescaler  = pre_reg;

endmodule
`default_nettype wire

@@ src/bank_switch_irq_mapper_unit.sv @@
// Top level of the bank switch IRQ mapper: sequencer, register decode and lookups.
//
// Usage: each req transaction carries one bus event (register write, CPU cycle tick,
// scanline end, PRG lookup or PPU lookup) and yields exactly one rsp transaction with
// the IRQ level after the event, the selected bank and the nametable page.
// req.ready is high only while the sequencer is idle; a transaction then passes through
// capture, execute and deliver, with one tick step per prescaled counter decrement
// of a cycle tick, 0 to 4, between execute and deliver. The decrements run one per
// cycle through the single counter decrementer of the IRQ unit.
// The result appears in the rsp output register the cycle after delivery.
// A stalled receiver holds the response; the next request is still accepted and
// executed, and waits in the deliver step until the output register frees up.
// cfg writes the variant select; cfg.ready is always high, write only when idle.
// Reset (rst_n low, asynchronous) clears all mapper state; bank registers 0 to 10
// read as 0xFF and the rest as 0 until written.
`default_nettype none
module bank_switch_irq_mapper_unit
    import bsim_pkg::*;
(
    input wire logic clk,
    input wire logic rst_n,
    bsim_req_if.sink   req,
    bsim_rsp_if.source rsp,
    bsim_cfg_if.sink   cfg
);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_EXEC = 4'b0010,
        ST_TICK = 4'b0100,
        ST_DONE = 4'b1000
    } state_t;

    state_t                state_reg, state_next;
    logic [2:0]            cmd_reg;
    logic [15:0]           addr_reg;
    logic [7:0]            data_reg;
    logic [3:0]            cycles_reg;
    logic [8:0]            line_reg;
    logic [7:0]            command_reg, command_next;
    logic                  mirror_reg, mirror_next;
    logic                  alt_reg;
    logic [TICK_BITS-1:0]  tick_reg, tick_next;
    logic                  rsp_valid_reg;
    logic                  irq_out_reg;
    logic [7:0]            bank_out_reg;
    logic                  page_out_reg;

    irq_ctrl_t             irq_ctrl;
    irq_status_t           irq_stat;
    logic                  bank_wr;
    logic [3:0]            rd_idx;
    logic [7:0]            rd_data;
    logic [15:0]           reg_addr;
    logic [SUM_BITS-1:0]   pre_sum;
    logic                  one_k;
    logic                  chr_sel;
    logic                  deliver;
    logic [7:0]            bank_val;
    logic                  page_val;

    assign reg_addr = addr_reg & REG_MASK;
    assign pre_sum  = {{(SUM_BITS-PRESCALE_BITS){1'b0}}, irq_stat.prescaler}
                    + {{(SUM_BITS-CYCLE_BITS){1'b0}}, cycles_reg};
    assign one_k    = command_reg[CMD_ONE_K_BIT];
    assign chr_sel  = (addr_reg[15:13] == 3'b000);
    assign deliver  = (state_reg == ST_DONE) && (!rsp_valid_reg || rsp.ready);

    always_comb
    begin
        if (cmd_reg == CMD_PRG)
        begin
            case (addr_reg[14:13])
                2'b00:   rd_idx = BANK_PRG0;
                2'b01:   rd_idx = BANK_PRG1;
                default: rd_idx = BANK_PRG2;
            endcase
        end
        else if (chr_sel && addr_reg[12])
        begin
            rd_idx = BANK_CHR_HIGH + {2'b00, addr_reg[11:10]};
        end
        else if (one_k && addr_reg[10])
        begin
            rd_idx = BANK_CHR_ALT + {3'b000, addr_reg[11]};
        end
        else
        begin
            rd_idx = {3'b000, addr_reg[11]};
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        command_next = command_reg;
        mirror_next  = mirror_reg;
        tick_next    = tick_reg;
        bank_wr      = 1'b0;
        irq_ctrl     = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (req.valid)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                state_next = ST_DONE;
                case (cmd_reg)
                    CMD_WRITE:
                    begin
                        case (reg_addr)
                            REG_COMMAND: command_next = data_reg;
                            REG_BANK:    bank_wr = 1'b1;
                            REG_MIRROR:  mirror_next = data_reg[0];
                            REG_LATCH:   irq_ctrl.latch_wr = 1'b1;
                            REG_MODE:    irq_ctrl.mode_wr = 1'b1;
                            REG_IRQ_ACK: irq_ctrl.ack = 1'b1;
                            REG_IRQ_EN:  irq_ctrl.enable = 1'b1;
                            default:     ;
                        endcase
                    end
                    CMD_CYCLE:
                    begin
                        if (irq_stat.cycle_mode)
                        begin
                            irq_ctrl.pre_load  = 1'b1;
                            irq_ctrl.pre_value = pre_sum[PRESCALE_BITS-1:0];
                            tick_next = pre_sum[SUM_BITS-1:PRESCALE_BITS];
                            if (pre_sum[SUM_BITS-1:PRESCALE_BITS] != '0)
                            begin
                                state_next = ST_TICK;
                            end
                        end
                    end
                    CMD_LINE:
                    begin
                        irq_ctrl.line_clk = !irq_stat.cycle_mode && (line_reg != LINE_SKIP);
                    end
                    default: ;
                endcase
            end
            ST_TICK:
            begin
                irq_ctrl.cyc_clk = 1'b1;
                tick_next = tick_reg - {{(TICK_BITS-1){1'b0}}, 1'b1};
                if (tick_reg == {{(TICK_BITS-1){1'b0}}, 1'b1})
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (deliver)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        bank_val = 8'h00;
        page_val = 1'b0;
        case (cmd_reg)
            CMD_PRG:
            begin
                if (!addr_reg[15])
                begin
                    bank_val = 8'h00;
                end
                else if (addr_reg[14:13] == 2'b11)
                begin
                    bank_val = BANK_LAST;
                end
                else
                begin
                    bank_val = rd_data;
                end
            end
            CMD_PPU:
            begin
                if (chr_sel)
                begin
                    if (addr_reg[12] || one_k)
                    begin
                        bank_val = rd_data;
                    end
                    else
                    begin
                        bank_val = {rd_data[7:1], addr_reg[10]};
                    end
                end
                else if (alt_reg)
                begin
                    page_val = rd_data[7];
                end
                else
                begin
                    page_val = mirror_reg ? addr_reg[11] : addr_reg[10];
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            command_reg   <= '0;
            mirror_reg    <= 1'b0;
            alt_reg       <= 1'b0;
            tick_reg      <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            command_reg <= command_next;
            mirror_reg  <= mirror_next;
            tick_reg    <= tick_next;
            if (cfg.valid)
            begin
                alt_reg <= cfg.variant_alt_nametable;
            end
            if (deliver)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            cmd_reg    <= req.command;
            addr_reg   <= req.address;
            data_reg   <= req.write_data;
            cycles_reg <= req.cycle_count;
            line_reg   <= req.line_number;
        end
        if (deliver)
        begin
            irq_out_reg  <= irq_stat.pending;
            bank_out_reg <= bank_val;
            page_out_reg <= page_val;
        end
    end

    bsim_bank_store u_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (bank_wr),
        .wr_idx  (command_reg[3:0]),
        .wr_data (data_reg),
        .rd_idx  (rd_idx),
        .rd_data (rd_data)
    );

    bsim_irq_unit u_irq (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (irq_ctrl),
        .data   (data_reg),
        .status (irq_stat)
    );

    assign req.ready          = (state_reg == ST_IDLE);
    assign cfg.ready          = 1'b1;
    assign rsp.valid          = rsp_valid_reg;
    assign rsp.irq_line       = irq_out_reg;
    assign rsp.bank_number    = bank_out_reg;
    assign rsp.nametable_page = page_out_reg;

    a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready) |=> (state_reg == ST_EXEC))
        else $error("accepted transaction did not enter execute");

    a_tick_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_TICK) |-> (tick_reg != '0))
        else $error("tick step with no decrement left");

    a_deliver_valid: assert property (@(posedge clk) disable iff (!rst_n)
        deliver |=> (rsp_valid_reg && (state_reg == ST_IDLE)))
        else $error("delivered response not presented");

endmodule
`default_nettype wire
